### rtl/stp_pkg.sv
package stp_pkg;

    localparam int PWM_BITS  = 12;
    localparam int DEG_W     = 14;
    localparam int RNG_W     = 13;
    localparam int TIME_W    = 32;
    localparam int RAMP_W    = 8;
    localparam int RAMP_MAX  = 102;
    localparam int P_W       = 17;
    localparam int P_ONE     = 65536;
    localparam int FRAC_STEPS = 16;
    localparam int DIV_STEPS = 50;
    localparam int NUM_W     = 50;
    localparam int DSR_W     = 34;
    localparam int QUO_W     = 18;
    localparam int CNT_W     = 6;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_TICK   = 2'd0;
    localparam cmd_t CMD_START  = 2'd1;
    localparam cmd_t CMD_DIRECT = 2'd2;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_PWM_MIN    = 3'd0;
    localparam reg_idx_t REG_PWM_MAX    = 3'd1;
    localparam reg_idx_t REG_RANGE      = 3'd2;
    localparam reg_idx_t REG_CORRECTION = 3'd3;
    localparam reg_idx_t REG_LIMIT_LOW  = 3'd4;
    localparam reg_idx_t REG_LIMIT_HIGH = 3'd5;
    localparam reg_idx_t REG_REVERSE    = 3'd6;
    localparam reg_idx_t REG_CHANNEL    = 3'd7;

endpackage

### rtl/servo_trapezoid_profile_pwm.sv
// Servo motion profile generator with a trapezoidal velocity ramp and PWM mapping.
// Requests arrive on the s_ channel (valid/ready) and carry a command, the current
// millisecond time, a target position in 1/16 degree, a duration and a Q0.8 ramp share.
// Every request produces exactly one result on the m_ channel (valid/ready): a PWM
// write flag and count, the channel, the current position and the motion flag.
// The block handles one request at a time and holds s_ready low until its result
// has been taken, so a stalled receiver simply holds off the next request.
// Start requests and requests that change nothing go from acceptance straight to the
// result. A direct write runs a 50-step floor division for the PWM count; a profile
// tick first adds a 16-step fraction division, two multiply stages and a 50-step
// rounding division for the position. One shared bit-serial restoring divider does
// all divisions, retiring one quotient bit per cycle. Configuration is written over
// the APB port at byte address 4*index. The user must write it only while idle; the
// block does not enforce this. After reset (aresetn low at a clock edge) the registers
// hold their defaults, the channel is unattached and no motion is in progress.
module servo_trapezoid_profile_pwm (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  stp_pkg::cmd_t                 s_cmd,
    input  logic [stp_pkg::TIME_W-1:0]    s_time_ms,
    input  logic signed [stp_pkg::DEG_W-1:0] s_target_degree,
    input  logic [stp_pkg::TIME_W-1:0]    s_duration_ms,
    input  logic [stp_pkg::RAMP_W-1:0]    s_ramp_frac,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_pwm_write,
    output logic [3:0]                    m_pwm_channel,
    output logic [stp_pkg::PWM_BITS-1:0]  m_pwm_count,
    output logic signed [stp_pkg::DEG_W-1:0] m_current_degree,
    output logic                          m_moving,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stp_pkg::ADDR_W-1:0]    paddr,
    input  logic [stp_pkg::DATA_W-1:0]    pwdata,
    output logic [stp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import stp_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIV   = 4'd1;
    localparam logic [3:0] ST_POST  = 4'd2;
    localparam logic [3:0] ST_MUL1  = 4'd3;
    localparam logic [3:0] ST_MUL2  = 4'd4;
    localparam logic [3:0] ST_CLAMP = 4'd5;
    localparam logic [3:0] ST_MAP   = 4'd6;
    localparam logic [3:0] ST_FIN   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    localparam logic [1:0] PH_FRAC = 2'd0;
    localparam logic [1:0] PH_POS  = 2'd1;
    localparam logic [1:0] PH_PWM  = 2'd2;

    logic [3:0]                 state_reg;
    logic [PWM_BITS-1:0]        pwm_min_reg, pwm_max_reg;
    logic [RNG_W-1:0]           range_reg, limit_low_reg, limit_high_reg;
    logic signed [DEG_W-1:0]    correction_reg;
    logic                       reverse_reg;
    logic [4:0]                 channel_reg;

    logic signed [DEG_W-1:0]    target_pos_reg, current_pos_reg, start_pos_reg;
    logic [TIME_W-1:0]          start_time_reg, end_time_reg;
    logic [RAMP_W-1:0]          ramp_share_reg;
    logic                       in_motion_reg;
    logic [PWM_BITS-1:0]        last_pwm_reg;

    logic [1:0]                 phase_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [DSR_W-1:0]           rem_reg, divisor_reg;
    logic [NUM_W-1:0]           num_reg;
    logic [QUO_W-1:0]           quo_reg;
    logic [P_W-1:0]             p_reg;
    logic [32:0]                a_reg, den_reg;
    logic                       sub_reg, neg_reg;
    logic signed [19:0]         pos_reg;
    logic [RNG_W-1:0]           x_reg;

    logic                       out_write_reg;
    logic [3:0]                 out_channel_reg;
    logic [PWM_BITS-1:0]        out_count_reg;
    logic signed [DEG_W-1:0]    out_degree_reg;
    logic                       out_moving_reg;

    logic                       attached;
    logic                       accept;
    logic [TIME_W-1:0]          elapsed, span, end_next;
    logic signed [DEG_W:0]      delta, deg_ext, lim_lo_ext, lim_hi_ext;
    logic signed [DEG_W-1:0]    target_next;
    logic [RAMP_W-1:0]          ramp_next;

    logic [P_W-1:0]             ramp_lo, ramp_hi, p_comp, sq_in, mid;
    logic [8:0]                 ramp_inv;
    logic [16:0]                ramp_prod;
    logic [33:0]                sq, qd;
    logic signed [48:0]         prod_pos;
    logic [47:0]                mag_pos;

    logic [34:0]                div_t, div_diff;
    logic                       div_ge;

    logic signed [19:0]         quo_signed, pos_calc, base_sum;
    logic signed [20:0]         x_sum, cur_calc;
    logic [RNG_W-1:0]           x_calc;
    logic signed [DEG_W-1:0]    cur_sat;

    logic signed [13:0]         pwm_diff, pwm_sdiff;
    logic signed [27:0]         prod_pwm;
    logic [26:0]                mag_pwm;
    logic [PWM_BITS-1:0]        pwm_base, count_calc;
    logic signed [19:0]         count_sum;

    logic                       cfg_write;
    reg_idx_t                   cfg_idx;

    assign attached = ~channel_reg[4];
    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_OUT);
    assign pready   = 1'b1;

    assign m_pwm_write      = out_write_reg;
    assign m_pwm_channel    = out_channel_reg;
    assign m_pwm_count      = out_count_reg;
    assign m_current_degree = out_degree_reg;
    assign m_moving         = out_moving_reg;

    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[4:2];

    always_comb begin
        unique case (cfg_idx)
            REG_PWM_MIN:    prdata = {{(DATA_W-PWM_BITS){1'b0}}, pwm_min_reg};
            REG_PWM_MAX:    prdata = {{(DATA_W-PWM_BITS){1'b0}}, pwm_max_reg};
            REG_RANGE:      prdata = {{(DATA_W-RNG_W){1'b0}}, range_reg};
            REG_CORRECTION: prdata = {{(DATA_W-DEG_W){1'b0}}, correction_reg};
            REG_LIMIT_LOW:  prdata = {{(DATA_W-RNG_W){1'b0}}, limit_low_reg};
            REG_LIMIT_HIGH: prdata = {{(DATA_W-RNG_W){1'b0}}, limit_high_reg};
            REG_REVERSE:    prdata = {{(DATA_W-1){1'b0}}, reverse_reg};
            REG_CHANNEL:    prdata = {{(DATA_W-5){1'b0}}, channel_reg};
            default:        prdata = '0;
        endcase
    end

    // Request decode: start clamping and profile timing.
    assign elapsed    = s_time_ms - start_time_reg;
    assign span       = end_time_reg - start_time_reg;
    assign end_next   = s_time_ms + s_duration_ms;
    assign delta      = $signed({target_pos_reg[DEG_W-1], target_pos_reg})
                      - $signed({start_pos_reg[DEG_W-1], start_pos_reg});
    assign deg_ext    = $signed({s_target_degree[DEG_W-1], s_target_degree});
    assign lim_lo_ext = $signed({2'b00, limit_low_reg});
    assign lim_hi_ext = $signed({2'b00, limit_high_reg});
    assign ramp_next  = (s_ramp_frac > RAMP_W'(RAMP_MAX)) ? RAMP_W'(RAMP_MAX) : s_ramp_frac;

    always_comb begin
        if (deg_ext < lim_lo_ext) begin
            target_next = $signed({1'b0, limit_low_reg});
        end else if (deg_ext > lim_hi_ext) begin
            target_next = $signed({1'b0, limit_high_reg});
        end else begin
            target_next = s_target_degree;
        end
    end

    // Ramp law selection and the first multiply stage.
    assign ramp_lo   = {1'b0, ramp_share_reg, 8'b0};
    assign ramp_inv  = 9'd256 - {1'b0, ramp_share_reg};
    assign ramp_hi   = {ramp_inv, 8'b0};
    assign p_comp    = P_W'(P_ONE) - p_reg;
    assign sq_in     = (p_reg < ramp_lo) ? p_reg : p_comp;
    assign sq        = sq_in * sq_in;
    assign mid       = p_reg - {2'b0, ramp_share_reg, 7'b0};
    assign ramp_prod = {1'b0, ramp_share_reg} * ramp_inv;
    assign qd        = {ramp_prod, 17'b0};

    // Second multiply stage: signed travel times the law term.
    assign prod_pos = $signed(delta) * $signed({1'b0, a_reg});
    assign mag_pos  = prod_pos[48] ? 48'(-prod_pos) : prod_pos[47:0];

    // Shared restoring divider, one quotient bit per cycle.
    assign div_t    = {rem_reg, num_reg[NUM_W-1]};
    assign div_diff = div_t - {1'b0, divisor_reg};
    assign div_ge   = (div_t >= {1'b0, divisor_reg});

    assign quo_signed = neg_reg ? -$signed({2'b0, quo_reg}) : $signed({2'b0, quo_reg});
    assign base_sum   = $signed({{6{start_pos_reg[DEG_W-1]}}, start_pos_reg});
    assign pos_calc   = sub_reg ? (base_sum + 20'($signed(delta)) - quo_signed)
                                : (base_sum + quo_signed);

    // Correction, clamp to travel and saturate the reported position.
    assign x_sum    = 21'(pos_reg) + 21'(correction_reg);
    assign x_calc   = (x_sum < 0) ? '0
                    : (x_sum > $signed({8'b0, range_reg})) ? range_reg : x_sum[RNG_W-1:0];
    assign cur_calc = $signed({8'b0, x_calc}) - 21'(correction_reg);
    assign cur_sat  = (cur_calc > 21'sd8191) ? 14'sd8191
                    : (cur_calc < -21'sd8192) ? -14'sd8192 : cur_calc[DEG_W-1:0];

    // PWM mapping.
    assign pwm_diff  = $signed({2'b0, pwm_max_reg}) - $signed({2'b0, pwm_min_reg});
    assign pwm_sdiff = reverse_reg ? pwm_diff : -pwm_diff;
    assign prod_pwm  = pwm_sdiff * $signed({1'b0, x_reg});
    assign mag_pwm   = prod_pwm[27] ? 27'(-prod_pwm) : prod_pwm[26:0];
    assign pwm_base  = reverse_reg ? pwm_min_reg : pwm_max_reg;
    assign count_sum = $signed({8'b0, pwm_base}) + quo_signed;
    assign count_calc = count_sum[PWM_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pwm_min_reg    <= PWM_BITS'(120);
            pwm_max_reg    <= PWM_BITS'(590);
            range_reg      <= RNG_W'(4320);
            correction_reg <= '0;
            limit_low_reg  <= '0;
            limit_high_reg <= RNG_W'(4320);
            reverse_reg    <= 1'b0;
            channel_reg    <= 5'h1F;
            target_pos_reg <= -14'sd1;
            current_pos_reg <= -14'sd1;
            start_pos_reg  <= '0;
            start_time_reg <= '0;
            end_time_reg   <= '0;
            ramp_share_reg <= '0;
            in_motion_reg  <= 1'b0;
            last_pwm_reg   <= '0;
            cnt_reg        <= '0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_idx)
                    REG_PWM_MIN:    pwm_min_reg    <= pwdata[PWM_BITS-1:0];
                    REG_PWM_MAX:    pwm_max_reg    <= pwdata[PWM_BITS-1:0];
                    REG_RANGE:      range_reg      <= pwdata[RNG_W-1:0];
                    REG_CORRECTION: correction_reg <= $signed(pwdata[DEG_W-1:0]);
                    REG_LIMIT_LOW:  limit_low_reg  <= pwdata[RNG_W-1:0];
                    REG_LIMIT_HIGH: limit_high_reg <= pwdata[RNG_W-1:0];
                    REG_REVERSE:    reverse_reg    <= pwdata[0];
                    REG_CHANNEL:    channel_reg    <= pwdata[4:0];
                    default:        ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        out_write_reg   <= 1'b0;
                        out_count_reg   <= '0;
                        out_channel_reg <= attached ? channel_reg[3:0] : 4'd0;
                        out_degree_reg  <= current_pos_reg;
                        out_moving_reg  <= in_motion_reg;
                        state_reg       <= ST_OUT;
                        case (s_cmd)
                            CMD_START: begin
                                target_pos_reg <= target_next;
                                ramp_share_reg <= ramp_next;
                                start_pos_reg  <= current_pos_reg;
                                start_time_reg <= s_time_ms;
                                end_time_reg   <= end_next;
                                in_motion_reg  <= 1'b1;
                                out_moving_reg <= 1'b1;
                            end
                            CMD_DIRECT: begin
                                if (attached) begin
                                    pos_reg   <= 20'(s_target_degree);
                                    state_reg <= ST_CLAMP;
                                end
                            end
                            CMD_TICK: begin
                                if (attached && in_motion_reg) begin
                                    if (s_time_ms >= end_time_reg) begin
                                        pos_reg       <= 20'(target_pos_reg);
                                        in_motion_reg <= 1'b0;
                                        state_reg     <= ST_CLAMP;
                                    end else if (target_pos_reg != current_pos_reg) begin
                                        if (span == '0 || elapsed >= span) begin
                                            p_reg     <= P_W'(P_ONE);
                                            state_reg <= ST_MUL1;
                                        end else begin
                                            rem_reg     <= {2'b0, elapsed};
                                            divisor_reg <= {2'b0, span};
                                            num_reg     <= '0;
                                            quo_reg     <= '0;
                                            cnt_reg     <= CNT_W'(FRAC_STEPS);
                                            phase_reg   <= PH_FRAC;
                                            state_reg   <= ST_DIV;
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DIV: begin
                    rem_reg <= div_ge ? div_diff[DSR_W-1:0] : div_t[DSR_W-1:0];
                    num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                    quo_reg <= {quo_reg[QUO_W-2:0], div_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= ST_POST;
                    end
                end
                ST_POST: begin
                    unique case (phase_reg)
                        PH_FRAC: begin
                            p_reg     <= quo_reg[P_W-1:0];
                            state_reg <= ST_MUL1;
                        end
                        PH_POS: begin
                            pos_reg   <= pos_calc;
                            state_reg <= ST_CLAMP;
                        end
                        default: begin
                            state_reg <= ST_FIN;
                        end
                    endcase
                end
                ST_MUL1: begin
                    sub_reg <= 1'b0;
                    if (ramp_share_reg == '0) begin
                        a_reg   <= {16'b0, p_reg};
                        den_reg <= 33'(P_ONE);
                    end else if (p_reg < ramp_lo) begin
                        a_reg   <= sq[32:0];
                        den_reg <= qd[32:0];
                    end else if (p_reg < ramp_hi) begin
                        a_reg   <= {16'b0, mid};
                        den_reg <= {16'b0, ramp_hi};
                    end else begin
                        a_reg   <= sq[32:0];
                        den_reg <= qd[32:0];
                        sub_reg <= 1'b1;
                    end
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    neg_reg     <= prod_pos[48];
                    num_reg     <= {1'b0, mag_pos, 1'b0} + {17'b0, den_reg};
                    divisor_reg <= {den_reg, 1'b0};
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    cnt_reg     <= CNT_W'(DIV_STEPS);
                    phase_reg   <= PH_POS;
                    state_reg   <= ST_DIV;
                end
                ST_CLAMP: begin
                    x_reg           <= x_calc;
                    current_pos_reg <= cur_sat;
                    state_reg       <= ST_MAP;
                end
                ST_MAP: begin
                    if (range_reg == '0) begin
                        quo_reg   <= '0;
                        neg_reg   <= 1'b0;
                        state_reg <= ST_FIN;
                    end else begin
                        neg_reg     <= prod_pwm[27];
                        num_reg     <= prod_pwm[27]
                                     ? NUM_W'(mag_pwm) + NUM_W'(range_reg) - NUM_W'(1)
                                     : NUM_W'(mag_pwm);
                        divisor_reg <= DSR_W'(range_reg);
                        rem_reg     <= '0;
                        quo_reg     <= '0;
                        cnt_reg     <= CNT_W'(DIV_STEPS);
                        phase_reg   <= PH_PWM;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_FIN: begin
                    out_channel_reg <= channel_reg[3:0];
                    out_degree_reg  <= current_pos_reg;
                    out_moving_reg  <= in_motion_reg;
                    if (count_calc != last_pwm_reg) begin
                        last_pwm_reg  <= count_calc;
                        out_write_reg <= 1'b1;
                        out_count_reg <= count_calc;
                    end else begin
                        out_write_reg <= 1'b0;
                        out_count_reg <= '0;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready stayed high after a request was taken");

    a_write_tracks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pwm_write) |-> (m_pwm_count == last_pwm_reg))
        else $error("issued count differs from the remembered count");

    a_quiet_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_pwm_write) |-> (m_pwm_count == '0))
        else $error("count is nonzero without a write");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg != '0))
        else $error("divider running with an empty step count");
`endif

endmodule

### tb/servo_trapezoid_profile_pwm_checker.sv
module servo_trapezoid_profile_pwm_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  stp_pkg::cmd_t                     s_cmd,
    input  logic [31:0]                       s_time_ms,
    input  logic signed [13:0]                s_target_degree,
    input  logic [31:0]                       s_duration_ms,
    input  logic [7:0]                        s_ramp_frac,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_pwm_write,
    input  logic [3:0]                        m_pwm_channel,
    input  logic [11:0]                       m_pwm_count,
    input  logic signed [13:0]                m_current_degree,
    input  logic                              m_moving,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stp_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output int                                fail_count,
    output int                                pending
);
    import stp_pkg::*;

    typedef struct packed {
        logic        wr;
        logic [3:0]  chan;
        logic [11:0] count;
        logic [13:0] deg;
        logic        mov;
    } servo_out_t;

    servo_out_t expected_q[$];

    logic [11:0] cfg_pmin, cfg_pmax;
    logic [12:0] cfg_range, cfg_llow, cfg_lhigh;
    logic signed [13:0] cfg_corr;
    logic cfg_rev;
    logic signed [4:0] cfg_chan;

    longint tgt, cur, spos;
    logic [31:0] t_start, t_end;
    longint ramp;
    logic motion;
    logic [11:0] last_count;

    assign pending = expected_q.size();

    function automatic longint round_div(longint num, longint den);
        longint mag, q;
        mag = num < 0 ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return num < 0 ? -q : q;
    endfunction

    function automatic longint floor_div(longint num, longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic longint profile_at(logic [31:0] now);
        logic [31:0] num, den;
        longint p, d, qd;
        num = now - t_start;
        den = t_end - t_start;
        d = tgt - spos;
        if (den == 0 || num >= den) p = 65536;
        else p = longint'({num, 16'h0} / {16'h0, den});
        if (ramp == 0) return spos + round_div(d * p, 65536);
        qd = 131072 * ramp * (256 - ramp);
        if (p < ramp * 256) return spos + round_div(d * p * p, qd);
        if (p < (256 - ramp) * 256)
            return spos + round_div(d * (p - 128 * ramp), 256 * (256 - ramp));
        p = 65536 - p;
        return spos + d - round_div(d * p * p, qd);
    endfunction

    task automatic apply_position(longint pos, inout servo_out_t r);
        longint x, c, diff, cnt;
        x = pos + cfg_corr;
        if (x < 0) x = 0;
        else if (x > cfg_range) x = cfg_range;
        c = x - cfg_corr;
        if (c > 8191) c = 8191;
        if (c < -8192) c = -8192;
        cur = c;
        diff = longint'(cfg_pmax) - longint'(cfg_pmin);
        if (cfg_range == 0) cnt = cfg_rev ? cfg_pmin : cfg_pmax;
        else if (cfg_rev) cnt = cfg_pmin + floor_div(diff * x, cfg_range);
        else cnt = cfg_pmax + floor_div(-diff * x, cfg_range);
        if (cnt[11:0] != last_count) begin
            last_count = cnt[11:0];
            r.wr = 1'b1;
            r.count = cnt[11:0];
        end
    endtask

    task automatic predict_request();
        servo_out_t r;
        longint deg;
        logic attached;
        r = '0;
        deg = s_target_degree;
        attached = cfg_chan >= 0;
        if (s_cmd == CMD_START) begin
            if (deg < longint'(cfg_llow)) deg = longint'(cfg_llow);
            else if (deg > longint'(cfg_lhigh)) deg = longint'(cfg_lhigh);
            tgt = deg;
            ramp = s_ramp_frac > RAMP_MAX ? RAMP_MAX : s_ramp_frac;
            spos = cur;
            t_start = s_time_ms;
            t_end = s_time_ms + s_duration_ms;
            motion = 1'b1;
        end else if (s_cmd == CMD_DIRECT) begin
            if (attached) apply_position(deg, r);
        end else if (s_cmd == CMD_TICK) begin
            if (attached && motion) begin
                if (s_time_ms >= t_end) begin
                    apply_position(tgt, r);
                    motion = 1'b0;
                end else if (tgt != cur) begin
                    apply_position(profile_at(s_time_ms), r);
                end
            end
        end
        r.chan = attached ? cfg_chan[3:0] : 4'd0;
        r.deg = cur[13:0];
        r.mov = motion;
        expected_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        servo_out_t e;
        if (!aresetn) begin
            cfg_pmin <= 12'd120; cfg_pmax <= 12'd590; cfg_range <= 13'd4320;
            cfg_corr <= '0; cfg_llow <= '0; cfg_lhigh <= 13'd4320;
            cfg_rev <= 1'b0; cfg_chan <= -5'sd1;
            tgt = -1; cur = -1; spos = 0; t_start = 0; t_end = 0; ramp = 0;
            motion = 1'b0; last_count = '0;
            expected_q.delete();
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite) begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_PWM_MIN:    cfg_pmin <= pwdata[11:0];
                    REG_PWM_MAX:    cfg_pmax <= pwdata[11:0];
                    REG_RANGE:      cfg_range <= pwdata[12:0];
                    REG_CORRECTION: cfg_corr <= pwdata[13:0];
                    REG_LIMIT_LOW:  cfg_llow <= pwdata[12:0];
                    REG_LIMIT_HIGH: cfg_lhigh <= pwdata[12:0];
                    REG_REVERSE:    cfg_rev <= pwdata[0];
                    REG_CHANNEL:    cfg_chan <= pwdata[4:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) predict_request();
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result wr=%0d cnt=%0d deg=%0d", $time,
                             m_pwm_write, m_pwm_count, m_current_degree);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e != {m_pwm_write, m_pwm_channel, m_pwm_count,
                              m_current_degree, m_moving}) begin
                        $display("%0t: mismatch expected wr=%0d ch=%0d cnt=%0d deg=%0d mov=%0d",
                                 $time, e.wr, e.chan, e.count, $signed(e.deg), e.mov);
                        $display("%0t:          actual   wr=%0d ch=%0d cnt=%0d deg=%0d mov=%0d",
                                 $time, m_pwm_write, m_pwm_channel, m_pwm_count,
                                 m_current_degree, m_moving);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/servo_trapezoid_profile_pwm_tb.sv
module servo_trapezoid_profile_pwm_tb;
    import stp_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    cmd_t s_cmd = CMD_TICK;
    logic [31:0] s_time_ms = '0;
    logic signed [13:0] s_target_degree = '0;
    logic [31:0] s_duration_ms = '0;
    logic [7:0] s_ramp_frac = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_pwm_write;
    logic [3:0] m_pwm_channel;
    logic [11:0] m_pwm_count;
    logic signed [13:0] m_current_degree;
    logic m_moving;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int fail_count, pending;
    int cycles = 0;
    int stall_mode = 0;
    logic [31:0] clock_ms = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    servo_trapezoid_profile_pwm u_dut (.*);
    servo_trapezoid_profile_pwm_checker u_chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= $urandom_range(0, 9) == 0;
            default: m_ready <= $urandom_range(0, 9) != 0;
        endcase
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_request(cmd_t c, logic [31:0] t, logic signed [13:0] deg,
                                logic [31:0] dur, logic [7:0] rf);
        s_valid <= 1'b1; s_cmd <= c; s_time_ms <= t;
        s_target_degree <= deg; s_duration_ms <= dur; s_ramp_frac <= rf;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic random_config(int mode);
        write_reg(REG_PWM_MIN, mode == 1 ? 0 : $urandom_range(0, 4095));
        write_reg(REG_PWM_MAX, mode == 1 ? 4095 : $urandom_range(0, 4095));
        write_reg(REG_RANGE, mode == 2 ? 1 : (mode == 1 ? 8191 : $urandom_range(1, 8191)));
        write_reg(REG_CORRECTION, mode == 1 ? -4320 : (mode == 2 ? 4320 :
                  $urandom_range(0, 8640) - 4320));
        write_reg(REG_LIMIT_LOW, $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191) : 0);
        write_reg(REG_LIMIT_HIGH, mode == 1 ? 8191 : $urandom_range(0, 8191));
        write_reg(REG_REVERSE, $urandom_range(0, 1));
        write_reg(REG_CHANNEL, $urandom_range(0, 15));
    endtask

    task automatic random_request();
        int k;
        logic [31:0] dur;
        k = $urandom_range(0, 99);
        dur = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 60);
        if (k < 15) begin
            send_request(CMD_START, clock_ms, 14'($urandom()), dur, 8'($urandom()));
        end else if (k < 22) begin
            send_request(CMD_DIRECT, $urandom(), 14'($urandom()), $urandom(),
                         8'($urandom()));
        end else if (k < 25) begin
            send_request(cmd_t'(2'd3), $urandom(), 14'($urandom()), $urandom(),
                         8'($urandom()));
        end else if (k < 30) begin
            send_request(CMD_TICK, $urandom(), 14'($urandom()), $urandom(),
                         8'($urandom()));
        end else begin
            clock_ms = clock_ms + $urandom_range(0, 5);
            send_request(CMD_TICK, clock_ms, 14'($urandom()), $urandom(), 8'($urandom()));
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_request(CMD_DIRECT, 0, 100, 0, 0);
        send_request(CMD_START, 0, 2000, 10, 50);
        send_request(CMD_TICK, 5, 0, 0, 0);
        send_request(cmd_t'(2'd3), 0, 0, 0, 0);
        drain();
        write_reg(REG_CHANNEL, 15);
        send_request(CMD_DIRECT, 0, 14'sh1fff, 0, 0);
        send_request(CMD_DIRECT, 0, -14'sd8192, 0, 0);
        send_request(CMD_START, 100, 14'sh1fff, 40, 255);
        for (int i = 0; i <= 42; i += 3) send_request(CMD_TICK, 100 + i, 0, 0, 0);
        send_request(CMD_START, 32'hffff_fff0, -14'sd8192, 32'h40, 0);
        send_request(CMD_TICK, 32'hffff_fff8, 0, 0, 0);
        send_request(CMD_TICK, 32'h10, 0, 0, 0);
        send_request(CMD_START, 50, 3000, 0, 102);
        send_request(CMD_TICK, 50, 0, 0, 0);
        send_request(CMD_START, 60, 1000, 32'hffff_ffff, 1);
        send_request(CMD_TICK, 10, 0, 0, 0);
        drain();
        write_reg(REG_RANGE, 0);
        write_reg(REG_LIMIT_LOW, 4000);
        write_reg(REG_LIMIT_HIGH, 100);
        write_reg(REG_REVERSE, 1);
        send_request(CMD_DIRECT, 0, 500, 0, 0);
        send_request(CMD_START, 0, 50, 4, 0);
        send_request(CMD_TICK, 9, 0, 0, 0);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            random_config(ph % 3);
            if (ph == 4) write_reg(REG_CHANNEL, 32'h1f);
            for (int n = 0; n < 110; ) begin
                int burst;
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < 110; b++, n++) random_request();
                if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 300)) @(negedge aclk);
                if ($urandom_range(0, 15) == 0) while (pending != 0) @(negedge aclk);
            end
            drain();
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### servo_trapezoid_profile_pwm.f
rtl/stp_pkg.sv
rtl/servo_trapezoid_profile_pwm.sv
tb/servo_trapezoid_profile_pwm_checker.sv
tb/servo_trapezoid_profile_pwm_tb.sv
